// ===== rtl/t2us_pkg.sv =====
// Shared constants and types for the tick-count to microseconds converter.
package t2us_pkg;

   localparam int unsigned TickWidth = 64;
   localparam int unsigned ScaleWidth = 20;
   localparam int unsigned ProductWidth = TickWidth + ScaleWidth;
   localparam int unsigned HalfWidth = TickWidth / 2;
   localparam int unsigned PartialWidth = HalfWidth + ScaleWidth;
   localparam int unsigned DivSteps = TickWidth;

   localparam logic [ScaleWidth-1:0] UsPerSecond = 20'd1000000;
   localparam logic [TickWidth-1:0] FreqReset = 64'd10000000;
   localparam logic [TickWidth-1:0] AllOnes = {TickWidth{1'b1}};

   typedef struct packed {
      logic [TickWidth-1:0] rem;
      logic [TickWidth-1:0] dq;
      logic                 zero;
      logic                 ovf;
   } div_stage_type;

endpackage

// ===== rtl/t2us_divider.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module t2us_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [t2us_pkg::TickWidth-1:0]   freq,
   input  logic                             in_valid,
   input  t2us_pkg::div_stage_type          in_data,
   output logic                             out_valid,
   output t2us_pkg::div_stage_type          out_data
);

   t2us_pkg::div_stage_type stage_ff [t2us_pkg::DivSteps];
   t2us_pkg::div_stage_type stage_in [t2us_pkg::DivSteps];
   t2us_pkg::div_stage_type stage_src [t2us_pkg::DivSteps];
   logic [t2us_pkg::DivSteps-1:0] valid_ff;
   logic [t2us_pkg::DivSteps-1:0] valid_in;

   genvar i;
   generate
      for (i = 0; i < t2us_pkg::DivSteps; i++) begin : g_step
         logic [t2us_pkg::TickWidth:0] rem_shift;
         logic [t2us_pkg::TickWidth:0] diff;
         logic                         take;

         if (i == 0) begin : g_first
            assign stage_src[i] = in_data;
            assign valid_in[i] = in_valid;
         end else begin : g_next
            assign stage_src[i] = stage_ff[i-1];
            assign valid_in[i] = valid_ff[i-1];
         end

         assign rem_shift = {stage_src[i].rem, stage_src[i].dq[t2us_pkg::TickWidth-1]};
         assign diff = rem_shift - {1'b0, freq};
         assign take = rem_shift >= {1'b0, freq};

         always_comb begin
            stage_in[i] = stage_src[i];
            stage_in[i].rem = take ? diff[t2us_pkg::TickWidth-1:0]
                                   : rem_shift[t2us_pkg::TickWidth-1:0];
            stage_in[i].dq = {stage_src[i].dq[t2us_pkg::TickWidth-2:0], take};
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               stage_ff[i] <= stage_in[i];
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff[t2us_pkg::DivSteps-1];
   assign out_data = stage_ff[t2us_pkg::DivSteps-1];

endmodule

// ===== rtl/ticks_to_microseconds_core.sv =====
// Top level of the tick-count to microseconds converter.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_tick_count (64 bits)
//   rsp_      out        rsp_valid / rsp_stall  rsp_microseconds (64 bits)
//   csr_      in         csr_valid / csr_ready  csr_counter_frequency (64 bits)
//
// A request passes from acceptance to its result through two multiply and
// add stages, one overflow check stage, 64 divider stages (one quotient bit
// each) and the output register. One request can enter in every cycle
// in which req_stall is low. The whole pipeline holds while a result waits
// on rsp_stall. Reset clears all valid bits and loads a frequency of 10 MHz.
module ticks_to_microseconds_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [t2us_pkg::TickWidth-1:0] req_tick_count,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [t2us_pkg::TickWidth-1:0] rsp_microseconds,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [t2us_pkg::TickWidth-1:0] csr_counter_frequency
);

   logic [t2us_pkg::TickWidth-1:0]    freq_ff;
   logic                              advance;

   logic                              valid_a_ff;
   logic [t2us_pkg::PartialWidth-1:0] pp_lo_ff;
   logic [t2us_pkg::PartialWidth-1:0] pp_hi_ff;
   logic [t2us_pkg::PartialWidth-1:0] pp_lo_in;
   logic [t2us_pkg::PartialWidth-1:0] pp_hi_in;

   logic                              valid_b_ff;
   logic [t2us_pkg::ProductWidth-1:0] product_ff;
   logic [t2us_pkg::ProductWidth-1:0] product_in;

   logic                              valid_c_ff;
   t2us_pkg::div_stage_type           entry_ff;
   t2us_pkg::div_stage_type           entry_in;
   logic [t2us_pkg::TickWidth-1:0]    high_part;

   logic                              div_valid;
   t2us_pkg::div_stage_type           div_data;

   logic                              rsp_valid_ff;
   logic [t2us_pkg::TickWidth-1:0]    rsp_microseconds_ff;
   logic [t2us_pkg::TickWidth-1:0]    rsp_microseconds_in;

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= t2us_pkg::FreqReset;
      end else if (csr_valid && csr_ready) begin
         freq_ff <= csr_counter_frequency;
      end
   end

   assign pp_lo_in = t2us_pkg::PartialWidth'(req_tick_count[t2us_pkg::HalfWidth-1:0])
                     * t2us_pkg::PartialWidth'(t2us_pkg::UsPerSecond);
   assign pp_hi_in = t2us_pkg::PartialWidth'(
                        req_tick_count[t2us_pkg::TickWidth-1:t2us_pkg::HalfWidth])
                     * t2us_pkg::PartialWidth'(t2us_pkg::UsPerSecond);

   assign product_in = t2us_pkg::ProductWidth'(pp_lo_ff)
                       + {pp_hi_ff, {t2us_pkg::HalfWidth{1'b0}}};

   assign high_part = t2us_pkg::TickWidth'(
      product_ff[t2us_pkg::ProductWidth-1:t2us_pkg::TickWidth]);

   // The quotient fits in 64 bits exactly when the bits above the low word
   // are below the frequency; that remainder also seeds the divider.
   always_comb begin
      entry_in.rem = high_part;
      entry_in.dq = product_ff[t2us_pkg::TickWidth-1:0];
      entry_in.zero = (freq_ff == '0);
      entry_in.ovf = (high_part >= freq_ff);
   end

   always_comb begin
      if (div_data.zero) begin
         rsp_microseconds_in = '0;
      end else if (div_data.ovf) begin
         rsp_microseconds_in = t2us_pkg::AllOnes;
      end else begin
         rsp_microseconds_in = div_data.dq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= req_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
         product_ff <= product_in;
         entry_ff <= entry_in;
         rsp_microseconds_ff <= rsp_microseconds_in;
      end
   end

   t2us_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .freq      (freq_ff),
      .in_valid  (valid_c_ff),
      .in_data   (entry_ff),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_microseconds = rsp_microseconds_ff;

endmodule
